// ===== sv/overcurrent_timeout_monitor_top_assert.svh =====
// Assertion macros for the overcurrent timeout monitor.
`ifndef OVERCURRENT_TIMEOUT_MONITOR_TOP_ASSERT_SVH
`define OVERCURRENT_TIMEOUT_MONITOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OCTM_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("overcurrent monitor: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OCTM_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("overcurrent monitor: next-cycle check failed");

`endif

// ===== sv/octm_pkg.sv =====
// Shared types and constants of the overcurrent timeout monitor.
package octm_pkg;

  localparam int unsigned DEF_CHANNELS = 4;
  localparam int unsigned DEF_SAMPLES  = 10;

  localparam int unsigned CHAN_W    = 2;
  localparam int unsigned ADC_W     = 10;
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned MASK_W    = 4;
  localparam int unsigned SUM_W     = 14;
  localparam int unsigned DUR_W     = 32;
  localparam int unsigned THR_W     = 16;
  localparam int unsigned INT_W     = 16;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned REG_IDX_W = 2;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned PROD_W    = SUM_W + GAIN_W;
  localparam int unsigned MIN_ALU_W = DUR_W + 1;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [SUM_W-1:0]  SUM_MAX   = '1;
  localparam logic [GAIN_W-1:0] GAIN_UV   = GAIN_W'(50000);  // per converter LSB, scaled
  localparam int                OFFSET_MA = 25000;           // 2.5 V offset in mA

  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_INTERVAL  = 2'd2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_ACCUM,
    ST_PROD,
    ST_CMP,
    ST_DUR,
    ST_HLT,
    ST_FINISH
  } state_e;

  typedef enum logic {
    ALU_ADD_SAT,
    ALU_LT
  } alu_op_e;

  typedef enum logic [2:0] {
    SEL_SINCE_INTERVAL,
    SEL_SINCE_ELAPSED,
    SEL_BOUND_PROD,
    SEL_DUR_SPAN,
    SEL_DUR_TIMEOUT
  } opsel_e;

  typedef struct packed {
    logic    ready;
    logic    load_item;
    alu_op_e op;
    opsel_e  sel;
    logic    sum_add;
    logic    since_add;
    logic    measure_start;
    logic    ok_wr;
    logic    dur_wr;
    logic    hlt_wr;
    logic    ch_next;
    logic    out_load;
  } ctrl_t;

  typedef struct packed {
    logic item_valid;
    logic is_tick;
    logic alu_lt;
    logic measuring;
    logic recheck;
    logic last_ch;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/octm_alu.sv =====
// Shared saturating adder and signed comparator of the monitor.
module octm_alu #(
  parameter int unsigned AW = octm_pkg::MIN_ALU_W
) (
  input  octm_pkg::alu_op_e                op_i,
  input  logic signed [AW-1:0]             a_i,
  input  logic signed [AW-1:0]             b_i,
  output logic [octm_pkg::DUR_W-1:0]       res_o,
  output logic                             lt_o
);

  logic [octm_pkg::DUR_W:0] sum;

  assign sum = {1'b0, a_i[octm_pkg::DUR_W-1:0]} + {1'b0, b_i[octm_pkg::DUR_W-1:0]};

  always_comb begin
    res_o = '0;
    lt_o  = 1'b0;
    unique case (op_i)
      octm_pkg::ALU_ADD_SAT: begin
        res_o = sum[octm_pkg::DUR_W] ? '1 : sum[octm_pkg::DUR_W-1:0];
      end
      octm_pkg::ALU_LT: begin
        lt_o = (a_i < b_i);
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

// ===== sv/octm_ctrl.sv =====
// Sequencer that steps the shared unit through one item.
module octm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  octm_pkg::stat_t stat_i,
  output octm_pkg::ctrl_t ctrl_o
);

  octm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= octm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    ctrl_o.op  = octm_pkg::ALU_LT;
    ctrl_o.sel = octm_pkg::SEL_SINCE_INTERVAL;
    unique case (state_q)
      octm_pkg::ST_IDLE: begin
        ctrl_o.ready = 1'b1;
        if (stat_i.item_valid) begin
          ctrl_o.load_item = 1'b1;
          state_d = octm_pkg::ST_DECIDE;
        end
      end
      octm_pkg::ST_DECIDE: begin
        if (!stat_i.is_tick) begin
          ctrl_o.sum_add = 1'b1;
          state_d = stat_i.recheck ? octm_pkg::ST_HLT : octm_pkg::ST_FINISH;
        end else if (stat_i.alu_lt) begin
          state_d = octm_pkg::ST_ACCUM;
        end else begin
          ctrl_o.measure_start = 1'b1;
          state_d = octm_pkg::ST_PROD;
        end
      end
      octm_pkg::ST_ACCUM: begin
        ctrl_o.op        = octm_pkg::ALU_ADD_SAT;
        ctrl_o.sel       = octm_pkg::SEL_SINCE_ELAPSED;
        ctrl_o.since_add = 1'b1;
        state_d = stat_i.recheck ? octm_pkg::ST_HLT : octm_pkg::ST_FINISH;
      end
      octm_pkg::ST_PROD: begin
        state_d = octm_pkg::ST_CMP;
      end
      octm_pkg::ST_CMP: begin
        ctrl_o.sel   = octm_pkg::SEL_BOUND_PROD;
        ctrl_o.ok_wr = 1'b1;
        state_d = octm_pkg::ST_DUR;
      end
      octm_pkg::ST_DUR: begin
        ctrl_o.op     = octm_pkg::ALU_ADD_SAT;
        ctrl_o.sel    = octm_pkg::SEL_DUR_SPAN;
        ctrl_o.dur_wr = 1'b1;
        state_d = octm_pkg::ST_HLT;
      end
      octm_pkg::ST_HLT: begin
        ctrl_o.sel    = octm_pkg::SEL_DUR_TIMEOUT;
        ctrl_o.hlt_wr = 1'b1;
        if (stat_i.last_ch) begin
          state_d = octm_pkg::ST_FINISH;
        end else begin
          ctrl_o.ch_next = 1'b1;
          state_d = stat_i.measuring ? octm_pkg::ST_PROD : octm_pkg::ST_HLT;
        end
      end
      octm_pkg::ST_FINISH: begin
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d = octm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = octm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/overcurrent_timeout_monitor_top.sv =====
// Top level of the multi-channel overcurrent timeout monitor.
//
// Multi-channel current monitor. A sample item (tuser 0) adds a 10-bit converter
// reading to its channel's sum, saturating at 16383; channels at or beyond
// CHANNELS are ignored. A tick item (tuser 1) either adds its elapsed milliseconds
// to the running time (saturating), or, once that time has reached the measure
// interval, runs a measurement and restarts the running time, the tick's own
// milliseconds being dropped. A measurement judges every channel exactly in
// integers (current_ok when 25000 - sum*50000/(1024*SAMPLES_PER_MEASURE) mA is
// below threshold), clears the duration of nominal channels, grows that of
// over-current channels by the running time (saturating) and clears the sums.
// Every item gives one result item: tdata[3:0] current-ok mask, tdata[7:4]
// healthy mask (duration below timeout), tdata[8] measured flag; only channels
// 0 to 3 appear. One sequencer drives a single saturating adder and
// comparator. A measuring tick steps each channel through product, compare,
// duration update and health compare. After a timeout_ms write the next item
// walks all channels once more for the health compare. A finished result waits
// in the output register without holding back the input side, except that a
// new result stalls until the previous one is taken. Configuration is a plain
// write port, index 0 threshold, 1 timeout, 2 measure interval; other indexes
// are ignored.
module overcurrent_timeout_monitor_top #(
  parameter int unsigned CHANNELS            = octm_pkg::DEF_CHANNELS,
  parameter int unsigned SAMPLES_PER_MEASURE = octm_pkg::DEF_SAMPLES
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // tdata: channel[1:0], adc_value[11:2], elapsed_ms[27:12], zero fill
  input  logic [octm_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  // tuser: opcode
  input  logic                                 s_axis_tuser_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // tdata: current_ok_mask[3:0], healthy_mask[7:4], measured[8], zero fill
  output logic [octm_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  input  logic                                 cfg_we_i,
  input  logic [octm_pkg::REG_IDX_W-1:0]       cfg_index_i,
  input  logic [octm_pkg::CFG_W-1:0]           cfg_data_i
);

  localparam int unsigned CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SCALE = 1024 * SAMPLES_PER_MEASURE;
  localparam int unsigned KW    = $clog2(SCALE + 1);
  localparam int unsigned AW    = (18 + KW > octm_pkg::MIN_ALU_W) ? 18 + KW
                                                                   : octm_pkg::MIN_ALU_W;
  localparam logic signed [AW-1:0] KS = AW'(SCALE);

  // configuration
  logic [octm_pkg::THR_W-1:0] thr_q;
  logic [octm_pkg::DUR_W-1:0] timeout_q;
  logic [octm_pkg::INT_W-1:0] interval_q;
  logic                       recheck_q;

  // item latch
  logic                           is_tick_q;
  logic [octm_pkg::CHAN_W-1:0]    chan_q;
  logic [octm_pkg::ADC_W-1:0]     adc_q;
  logic [octm_pkg::ELAPSED_W-1:0] elapsed_q;

  // monitor state
  logic [octm_pkg::SUM_W-1:0] sum_q [CHANNELS];
  logic [octm_pkg::DUR_W-1:0] dur_q [CHANNELS];
  logic [CHANNELS-1:0]        ok_q;
  logic [CHANNELS-1:0]        healthy_q;
  logic [octm_pkg::DUR_W-1:0] since_q;
  logic [octm_pkg::DUR_W-1:0] span_q;
  logic                       meas_q;
  logic [CW-1:0]              ch_q;

  // datapath
  logic signed [AW-1:0]        bound_q, bound_d;
  logic signed [octm_pkg::THR_W:0] diff;
  logic [octm_pkg::PROD_W-1:0] prod_q, prod_d;
  logic [CW-1:0]               rd_idx;
  logic [octm_pkg::SUM_W-1:0]  sum_rd;
  logic [octm_pkg::SUM_W:0]    sum_inc;
  logic                        chan_ok;
  logic                        last_ch;

  logic signed [AW-1:0]        alu_a, alu_b;
  logic [octm_pkg::DUR_W-1:0]  alu_res;
  logic                        alu_lt;

  // output register
  logic                             out_valid_q;
  logic [octm_pkg::OUT_DATA_W-1:0]  out_data_q;
  logic [CHANNELS+octm_pkg::MASK_W-1:0] ok_ext, hlt_ext;

  octm_pkg::ctrl_t ctrl;
  octm_pkg::stat_t stat;

  assign last_ch = (ch_q == CW'(CHANNELS - 1));
  assign chan_ok = (int'(chan_q) < int'(CHANNELS));
  assign rd_idx  = ctrl.sum_add ? CW'(chan_q) : ch_q;
  assign sum_rd  = sum_q[rd_idx];
  assign sum_inc = {1'b0, sum_rd} + (octm_pkg::SUM_W + 1)'(adc_q);

  // Threshold bound: (25000 - threshold) * 1024 * S, compared against sum * 50000.
  assign diff    = $signed((octm_pkg::THR_W + 1)'(octm_pkg::OFFSET_MA))
                 - $signed({thr_q[octm_pkg::THR_W-1], thr_q});
  assign bound_d = AW'(AW'(diff) * KS);
  assign prod_d  = octm_pkg::PROD_W'(sum_rd) * octm_pkg::PROD_W'(octm_pkg::GAIN_UV);

  always_ff @(posedge clk_i) begin
    bound_q <= bound_d;
    prod_q  <= prod_d;
  end

  // operand selection for the shared unit
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (ctrl.sel)
      octm_pkg::SEL_SINCE_INTERVAL: begin
        alu_a = AW'(since_q);
        alu_b = AW'(interval_q);
      end
      octm_pkg::SEL_SINCE_ELAPSED: begin
        alu_a = AW'(since_q);
        alu_b = AW'(elapsed_q);
      end
      octm_pkg::SEL_BOUND_PROD: begin
        alu_a = bound_q;
        alu_b = AW'(prod_q);
      end
      octm_pkg::SEL_DUR_SPAN: begin
        alu_a = AW'(dur_q[ch_q]);
        alu_b = AW'(span_q);
      end
      octm_pkg::SEL_DUR_TIMEOUT: begin
        alu_a = AW'(dur_q[ch_q]);
        alu_b = AW'(timeout_q);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  octm_alu #(
    .AW (AW)
  ) u_alu (
    .op_i  (ctrl.op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res),
    .lt_o  (alu_lt)
  );

  assign stat.item_valid = s_axis_tvalid_i;
  assign stat.is_tick    = is_tick_q;
  assign stat.alu_lt     = alu_lt;
  assign stat.measuring  = meas_q;
  assign stat.recheck    = recheck_q;
  assign stat.last_ch    = last_ch;
  assign stat.out_free   = !out_valid_q || m_axis_tready_i;

  octm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  assign s_axis_tready_o = ctrl.ready;

  // item latch, payload only
  always_ff @(posedge clk_i) begin
    if (ctrl.load_item) begin
      is_tick_q <= (s_axis_tuser_i == octm_pkg::OP_TICK);
      chan_q    <= s_axis_tdata_i[1:0];
      adc_q     <= s_axis_tdata_i[11:2];
      elapsed_q <= s_axis_tdata_i[27:12];
    end
  end

  // configuration registers; a new timeout forces a health recompute
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= '0;
      timeout_q  <= '0;
      interval_q <= '0;
      recheck_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          octm_pkg::REG_THRESHOLD: thr_q      <= cfg_data_i[octm_pkg::THR_W-1:0];
          octm_pkg::REG_TIMEOUT:   timeout_q  <= cfg_data_i;
          octm_pkg::REG_INTERVAL:  interval_q <= cfg_data_i[octm_pkg::INT_W-1:0];
          default: begin
          end
        endcase
      end
      if (cfg_we_i && cfg_index_i == octm_pkg::REG_TIMEOUT) begin
        recheck_q <= 1'b1;
      end else if (ctrl.hlt_wr && last_ch) begin
        recheck_q <= 1'b0;
      end
    end
  end

  // sequencer-driven state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        sum_q[c] <= '0;
        dur_q[c] <= '0;
      end
      ok_q      <= '0;
      healthy_q <= '0;
      since_q   <= '0;
      span_q    <= '0;
      meas_q    <= 1'b0;
      ch_q      <= '0;
    end else begin
      if (ctrl.load_item) begin
        meas_q <= 1'b0;
        ch_q   <= '0;
      end
      if (ctrl.ch_next) begin
        ch_q <= ch_q + CW'(1);
      end
      if (ctrl.sum_add && chan_ok) begin
        sum_q[rd_idx] <= sum_inc[octm_pkg::SUM_W] ? octm_pkg::SUM_MAX
                                                  : sum_inc[octm_pkg::SUM_W-1:0];
      end
      if (ctrl.since_add) begin
        since_q <= alu_res;
      end
      if (ctrl.measure_start) begin
        span_q  <= since_q;
        since_q <= '0;
        meas_q  <= 1'b1;
      end
      // the product of this channel's sum is already captured
      if (ctrl.ok_wr) begin
        ok_q[ch_q]  <= alu_lt;
        sum_q[ch_q] <= '0;
      end
      if (ctrl.dur_wr) begin
        dur_q[ch_q] <= ok_q[ch_q] ? '0 : alu_res;
      end
      if (ctrl.hlt_wr) begin
        healthy_q[ch_q] <= alu_lt;
      end
    end
  end

  // result register
  assign ok_ext  = {{octm_pkg::MASK_W{1'b0}}, ok_q};
  assign hlt_ext = {{octm_pkg::MASK_W{1'b0}}, healthy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_data_q <= {7'b0, meas_q, hlt_ext[octm_pkg::MASK_W-1:0],
                     ok_ext[octm_pkg::MASK_W-1:0]};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`include "overcurrent_timeout_monitor_top_assert.svh"

  // only tick items move the running time
  `OCTM_ASSERT_NOW(a_since_tick_only, ctrl.since_add || ctrl.measure_start, is_tick_q)
  // a measurement restarts the running time
  `OCTM_ASSERT_NEXT(a_since_restart, ctrl.measure_start, since_q == '0)
  // a channel within threshold carries no over-current duration
  `OCTM_ASSERT_NOW(a_ok_zero_dur, ctrl.hlt_wr && ok_q[ch_q], dur_q[ch_q] == '0)

endmodule
